[src/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the lru key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int KEY_W           = 31;
	localparam int VAL_W           = 31;
	localparam int CAP_W           = 5;
	localparam int DEF_MAX_ENTRIES = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// apb port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_CAPACITY = reg_idx_t'(0);

	typedef enum logic {
		FUNC_LOOKUP = 1'b0,
		FUNC_WRITE  = 1'b1
	} func_t;

endpackage

[src/lkv_if.sv]
// ----------------------------------------------------------------------------
// lkv_req_if / lkv_rsp_if
// Valid/ready channels for cache requests and responses.
// ----------------------------------------------------------------------------
interface lkv_req_if;

	logic                          valid;
	logic                          ready;
	lkv_pkg::func_t                func;
	logic [lkv_pkg::KEY_W-1:0]     lookup_key;
	logic [lkv_pkg::VAL_W-1:0]     write_value;

	modport source (output valid, output func, output lookup_key, output write_value,
		input ready);
	modport sink (input valid, input func, input lookup_key, input write_value,
		output ready);

endinterface

interface lkv_rsp_if;

	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [lkv_pkg::VAL_W-1:0]     read_value;
	logic                          evicted;

	modport source (output valid, output found, output read_value, output evicted,
		input ready);
	modport sink (input valid, input found, input read_value, input evicted,
		output ready);

endinterface

[src/lkv_cfg.sv]
// ----------------------------------------------------------------------------
// lkv_cfg
// APB register file holding the capacity register.
// ----------------------------------------------------------------------------
module lkv_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lkv_pkg::PADDR_W-1:0]   paddr,
	input  logic [lkv_pkg::PDATA_W-1:0]   pwdata,
	output logic [lkv_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [lkv_pkg::CAP_W-1:0]     capacity
);

	lkv_pkg::reg_idx_t reg_idx;
	logic              wr_en;

	assign reg_idx = paddr[lkv_pkg::PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity <= lkv_pkg::CAP_RESET;
		end else if (wr_en && reg_idx == lkv_pkg::REG_CAPACITY) begin
			capacity <= pwdata[lkv_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == lkv_pkg::REG_CAPACITY) begin
			prdata = lkv_pkg::PDATA_W'(capacity);
		end
	end

endmodule

[src/lkv_ram.sv]
// ----------------------------------------------------------------------------
// lkv_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lkv_ram #(
	parameter int DEPTH = lkv_pkg::DEF_MAX_ENTRIES,
	parameter int WIDTH = lkv_pkg::KEY_W
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/lkv_ctrl.sv]
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer sweeping the slot memories: search pass, then for a write an age update pass.
// ----------------------------------------------------------------------------
module lkv_ctrl #(
	parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lkv_pkg::CAP_W-1:0]  capacity,
	lkv_req_if.sink                    req,
	lkv_rsp_if.source                  rsp
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int AGE_W = IDX_W;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [CMP_W-1:0] MAX_CAP  = CMP_W'(MAX_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_DONE
	} state_t;

	state_t                     state_q;
	lkv_pkg::func_t             func_q;
	logic [lkv_pkg::KEY_W-1:0]  key_q;
	logic [lkv_pkg::VAL_W-1:0]  val_q;

	// sweep address and read stage
	logic [IDX_W-1:0]           idx_q;
	logic                       issue_q;
	logic                       run_s1;
	logic                       last_s1;
	logic [IDX_W-1:0]           idx_s1;

	// search results
	logic                       hit_q;
	logic [IDX_W-1:0]           hit_idx_q;
	logic [AGE_W-1:0]           hit_age_q;
	logic [lkv_pkg::VAL_W-1:0]  hit_val_q;
	logic                       old_vld_q;
	logic [IDX_W-1:0]           old_idx_q;
	logic [AGE_W-1:0]           old_age_q;
	logic                       free_vld_q;
	logic [IDX_W-1:0]           free_idx_q;
	logic                       evict_q;
	logic [IDX_W-1:0]           ins_idx_q;

	logic [MAX_ENTRIES-1:0]     valid_q;
	logic [CNT_W-1:0]           used_q;

	logic                       rsp_valid_q;
	logic                       found_q;
	logic [lkv_pkg::VAL_W-1:0]  read_value_q;
	logic                       evicted_q;

	// memory read data, aligned with idx_s1
	logic [lkv_pkg::KEY_W-1:0]  rd_key;
	logic [lkv_pkg::VAL_W-1:0]  rd_val;
	logic [AGE_W-1:0]           rd_age;

	logic                       slot_vld_s1;
	logic [CMP_W-1:0]           cap_ext;
	logic [CMP_W-1:0]           eff_cap;
	logic                       evict_c;
	logic [IDX_W-1:0]           ins_c;
	logic [MAX_ENTRIES-1:0]     valid_ins;
	logic                       key_we;
	logic                       val_we;
	logic [IDX_W-1:0]           kv_waddr;
	logic                       age_we;
	logic [AGE_W-1:0]           new_age;
	logic                       is_write;

	assign is_write    = (func_q == lkv_pkg::FUNC_WRITE);
	assign slot_vld_s1 = valid_q[idx_s1];

	// capacity clamped to 1 .. MAX_ENTRIES
	always_comb begin
		cap_ext = CMP_W'(capacity);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > MAX_CAP) begin
			eff_cap = MAX_CAP;
		end else begin
			eff_cap = cap_ext;
		end
	end

	always_comb begin
		evict_c = !hit_q && (CMP_W'(used_q) >= eff_cap) && (used_q != '0);
		if (evict_c) begin
			ins_c = (free_vld_q && free_idx_q < old_idx_q) ? free_idx_q : old_idx_q;
		end else begin
			ins_c = free_idx_q;
		end
	end

	// valid flags after a write miss: drop the oldest if evicting, then mark the insert
	always_comb begin
		valid_ins = valid_q;
		if (evict_c) begin
			valid_ins[old_idx_q] = 1'b0;
		end
		valid_ins[ins_c] = 1'b1;
	end

	// key and value writes happen once, in the decide step
	always_comb begin
		key_we   = (state_q == ST_DECIDE) && is_write && !hit_q;
		val_we   = (state_q == ST_DECIDE) && is_write;
		kv_waddr = hit_q ? hit_idx_q : ins_c;
	end

	// age rewrite during the update pass, valid flags already final
	always_comb begin
		age_we  = (state_q == ST_UPDATE) && run_s1;
		new_age = rd_age;
		if (hit_q) begin
			if (idx_s1 == hit_idx_q) begin
				new_age = '0;
			end else if (slot_vld_s1 && rd_age < hit_age_q) begin
				new_age = rd_age + AGE_W'(1);
			end
		end else begin
			if (idx_s1 == ins_idx_q) begin
				new_age = '0;
			end else if (slot_vld_s1) begin
				new_age = rd_age + AGE_W'(1);
			end
		end
	end

	lkv_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(lkv_pkg::KEY_W)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (kv_waddr),
		.wdata (key_q),
		.raddr (idx_q),
		.rdata (rd_key)
	);

	lkv_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(lkv_pkg::VAL_W)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (kv_waddr),
		.wdata (val_q),
		.raddr (idx_q),
		.rdata (rd_val)
	);

	lkv_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(AGE_W)) u_age_ram (
		.clk   (clk),
		.we    (age_we),
		.waddr (idx_s1),
		.wdata (new_age),
		.raddr (idx_q),
		.rdata (rd_age)
	);

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.found      = found_q;
	assign rsp.read_value = read_value_q;
	assign rsp.evicted    = evicted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 1'b0;
			run_s1      <= 1'b0;
			last_s1     <= 1'b0;
			hit_q       <= 1'b0;
			old_vld_q   <= 1'b0;
			free_vld_q  <= 1'b0;
			evict_q     <= 1'b0;
			valid_q     <= '0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// sweep address generator
			run_s1  <= issue_q;
			idx_s1  <= idx_q;
			last_s1 <= issue_q && (idx_q == LAST_IDX);
			if (issue_q) begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end
			end

			// the done step reloads the output register itself
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						func_q     <= req.func;
						key_q      <= req.lookup_key;
						val_q      <= req.write_value;
						idx_q      <= '0;
						issue_q    <= 1'b1;
						hit_q      <= 1'b0;
						old_vld_q  <= 1'b0;
						free_vld_q <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (run_s1) begin
						if (slot_vld_s1 && rd_key == key_q && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
							hit_age_q <= rd_age;
							hit_val_q <= rd_val;
						end
						if (slot_vld_s1 && (!old_vld_q || rd_age > old_age_q)) begin
							old_vld_q <= 1'b1;
							old_idx_q <= idx_s1;
							old_age_q <= rd_age;
						end
						if (!slot_vld_s1 && !free_vld_q) begin
							free_vld_q <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (last_s1) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					evict_q   <= is_write && evict_c;
					ins_idx_q <= ins_c;
					if (is_write) begin
						if (!hit_q) begin
							if (!evict_c) begin
								used_q <= used_q + CNT_W'(1);
							end
							valid_q <= valid_ins;
						end
						idx_q   <= '0;
						issue_q <= 1'b1;
						state_q <= ST_UPDATE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_UPDATE: begin
					if (run_s1 && last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						found_q      <= hit_q;
						read_value_q <= (!is_write && hit_q) ? hit_val_q : '0;
						evicted_q    <= evict_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least recently used replacement.
// ----------------------------------------------------------------------------
// Each request transaction is a lookup or a write and yields exactly one
// response transaction. A lookup reports found and the stored value (zero on
// a miss) and leaves the recency order alone. A write updates a present key
// and makes it most recently used, or inserts an absent key, first evicting
// the least recently used entry when the number held has reached the
// capacity register (clamped to 1 .. MAX_ENTRIES; lowering it below the
// current fill only makes each later insert evict one entry). The slot keys,
// values and ages live in memories that a small sequencer sweeps through one
// read port: a lookup makes one search sweep before the next request can be
// taken, a write one search sweep plus one age rewrite sweep, each sweep one
// slot per cycle behind the registered read. A finished response waits in an
// output register, so the next request is taken while it is still pending.
// The capacity register sits at APB byte address 0 and resets to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lkv_pkg::PADDR_W-1:0]   paddr,
	input  logic [lkv_pkg::PDATA_W-1:0]   pwdata,
	output logic [lkv_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	// request and response channels
	lkv_req_if.sink                       req,
	lkv_rsp_if.source                     rsp
);

	// capacity as last written over apb
	logic [lkv_pkg::CAP_W-1:0] capacity;

	lkv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	// search and replacement sequencer with the slot memories
	lkv_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity),
		.req      (req),
		.rsp      (rsp)
	);

endmodule

[test/tb_lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the lru key-value cache.
// ----------------------------------------------------------------------------
// A short directed table runs first: it covers the key and value extremes,
// hits and misses of both operations, and the capacity corner cases. Those
// cases are a capacity of zero, a capacity above the slot count, and a
// capacity lowered below the current fill. Random phases follow, each at its
// own capacity, drawing keys from a small pool so that hits and evictions
// are frequent. A behavioral copy of the cache predicts every response
// transaction, and a monitor compares each one field by field.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

	localparam int CACHE_DEPTH  = lkv_pkg::DEF_MAX_ENTRIES;
	localparam int AGE_W        = $clog2(CACHE_DEPTH);
	// a write sweeps the slots twice, so this covers the slowest item
	localparam int SETTLE_CYCLES = 2 * CACHE_DEPTH + 8;
	localparam int PHASE_ITEMS  = 170;
	localparam int PHASES       = 6;

	typedef struct packed {
		logic                      found;
		logic [lkv_pkg::VAL_W-1:0] read_value;
		logic                      evicted;
	} cache_rsp_t;

	typedef enum logic {
		ROW_ACCESS   = 1'b0,
		ROW_CAPACITY = 1'b1
	} row_kind_t;

	// one line of the directed table: a request transaction or a capacity write
	typedef struct {
		row_kind_t                 kind;
		lkv_pkg::func_t            func;
		logic [lkv_pkg::KEY_W-1:0] key;
		logic [lkv_pkg::VAL_W-1:0] value;
		logic [lkv_pkg::CAP_W-1:0] cap;
		bit                        typed;
		cache_rsp_t                rsp;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [lkv_pkg::PADDR_W-1:0]   paddr;
	logic [lkv_pkg::PDATA_W-1:0]   pwdata;
	logic [lkv_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;

	lkv_req_if req_ch ();
	lkv_rsp_if rsp_ch ();

	lru_key_value_cache #(
		.MAX_ENTRIES(CACHE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// shadow copy of the cache contents and the capacity register
	logic                      cache_valid [CACHE_DEPTH];
	logic [lkv_pkg::KEY_W-1:0] cache_key   [CACHE_DEPTH];
	logic [lkv_pkg::VAL_W-1:0] cache_value [CACHE_DEPTH];
	logic [AGE_W-1:0]          cache_age   [CACHE_DEPTH];
	logic [lkv_pkg::CAP_W:0]   cache_fill;
	logic [lkv_pkg::CAP_W-1:0] cache_cap;

	// responses still owed by the dut, oldest first
	cache_rsp_t pending_rsp_q [$];
	stim_row_t  directed_rows [$];
	int         mismatch_count;
	// set during the stretch where neither side idles
	bit         quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// predicts one access and updates the shadow copy
	function automatic cache_rsp_t predict_access(lkv_pkg::func_t f,
			logic [lkv_pkg::KEY_W-1:0] key, logic [lkv_pkg::VAL_W-1:0] val);
		cache_rsp_t                r;
		int                        hit;
		int                        oldest;
		int                        free_idx;
		logic [lkv_pkg::CAP_W-1:0] eff_cap;
		logic [AGE_W-1:0]          hit_age;
		r = '0;
		hit = -1;
		oldest = -1;
		free_idx = -1;
		// zero behaves as one, anything above the slot count saturates
		if (cache_cap == '0)
			eff_cap = lkv_pkg::CAP_W'(1);
		else if (cache_cap > CACHE_DEPTH)
			eff_cap = lkv_pkg::CAP_W'(CACHE_DEPTH);
		else
			eff_cap = cache_cap;
		for (int i = 0; i < CACHE_DEPTH; i++)
			if (hit < 0 && cache_valid[i] && cache_key[i] == key)
				hit = i;
		r.found = (hit >= 0);
		if (f == lkv_pkg::FUNC_LOOKUP) begin
			// recency order is left alone on a lookup
			if (hit >= 0)
				r.read_value = cache_value[hit];
		end else if (hit >= 0) begin
			// update in place: everything younger than the hit ages by one
			hit_age = cache_age[hit];
			for (int i = 0; i < CACHE_DEPTH; i++)
				if (cache_valid[i] && cache_age[i] < hit_age)
					cache_age[i]++;
			cache_age[hit] = '0;
			cache_value[hit] = val;
		end else begin
			// a full store (or one over capacity) drops exactly one entry
			if (cache_fill >= eff_cap && cache_fill != '0) begin
				for (int i = 0; i < CACHE_DEPTH; i++)
					if (cache_valid[i] && (oldest < 0 || cache_age[i] > cache_age[oldest]))
						oldest = i;
				cache_valid[oldest] = 1'b0;
				cache_fill--;
				r.evicted = 1'b1;
			end
			for (int i = 0; i < CACHE_DEPTH; i++)
				if (free_idx < 0 && !cache_valid[i])
					free_idx = i;
			for (int i = 0; i < CACHE_DEPTH; i++)
				if (cache_valid[i])
					cache_age[i]++;
			cache_valid[free_idx] = 1'b1;
			cache_key[free_idx] = key;
			cache_value[free_idx] = val;
			cache_age[free_idx] = '0;
			cache_fill++;
		end
		return r;
	endfunction

	// presents one request transaction and waits for it to be taken
	// entered and left at a rising edge; valid stays high on leaving
	task automatic issue_request(lkv_pkg::func_t f, logic [lkv_pkg::KEY_W-1:0] key,
			logic [lkv_pkg::VAL_W-1:0] val, bit typed, cache_rsp_t typed_rsp);
		int         gap;
		cache_rsp_t predicted;
		gap = (!quiet && $urandom_range(99) < 6) ? $urandom_range(40, 1) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.func        <= f;
		req_ch.lookup_key  <= key;
		req_ch.write_value <= val;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = predict_access(f, key, val);
		pending_rsp_q.push_back(typed ? typed_rsp : predicted);
	endtask

	// lets every outstanding response drain before touching the register
	task automatic settle_idle();
		req_ch.valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle; upper data bits are noise
	task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= lkv_pkg::PADDR_W'({lkv_pkg::REG_CAPACITY, 2'b00});
		pwdata  <= {(lkv_pkg::PDATA_W-lkv_pkg::CAP_W)'($urandom), cap};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cache_cap = cap;
	endtask

	// receiver side: ready drops at random about six times in a hundred, except in the quiet stretch
	always @(posedge clk) begin
		rsp_ch.ready <= quiet || ($urandom_range(99) >= 6);
	end

	// compare each response transaction with the oldest prediction
	always @(posedge clk) begin : rsp_check
		cache_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp_q.size() == 0) begin
				$error("response transaction with nothing outstanding");
				mismatch_count++;
			end else begin
				want = pending_rsp_q.pop_front();
				if (rsp_ch.found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
					mismatch_count++;
				end
				if (rsp_ch.read_value !== want.read_value) begin
					$error("read_value: expected %0h, actual %0h", want.read_value,
						rsp_ch.read_value);
					mismatch_count++;
				end
				if (rsp_ch.evicted !== want.evicted) begin
					$error("evicted: expected %0d, actual %0d", want.evicted, rsp_ch.evicted);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		logic [lkv_pkg::CAP_W-1:0] cap_plan [PHASES];
		logic [lkv_pkg::KEY_W-1:0] key_pool [$];
		logic [lkv_pkg::KEY_W-1:0] key;
		lkv_pkg::func_t            f;
		int                        pool_size;
		stim_row_t                 row;

		mismatch_count = 0;
		quiet          = 1'b0;
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.func        <= lkv_pkg::FUNC_LOOKUP;
		req_ch.lookup_key  <= '0;
		req_ch.write_value <= '0;

		// shadow copy starts empty, capacity at its reset value
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			cache_valid[i] = 1'b0;
			cache_key[i]   = '0;
			cache_value[i] = '0;
			cache_age[i]   = '0;
		end
		cache_fill = '0;
		cache_cap  = lkv_pkg::CAP_RESET;

		// directed table; typed results are the ones obvious from an empty store
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 31'h0, 31'h1234_5678,
			5'd0, 1'b1, cache_rsp_t'{1'b0, 31'h0, 1'b0}});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 5'd0, 1'b1, cache_rsp_t'{1'b0, 31'h0, 1'b0}});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h0, 31'h7FFF_FFFF,
			5'd0, 1'b1, cache_rsp_t'{1'b0, 31'h0, 1'b0}});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h7FFF_FFFF, 31'h0,
			5'd0, 1'b1, cache_rsp_t'{1'b0, 31'h0, 1'b0}});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 31'h0, 31'h0,
			5'd0, 1'b1, cache_rsp_t'{1'b1, 31'h7FFF_FFFF, 1'b0}});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 31'h7FFF_FFFF,
			31'h2AAA_AAAA, 5'd0, 1'b1, cache_rsp_t'{1'b1, 31'h0, 1'b0}});
		// write hit returns no data
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h0, 31'h2AAA_AAAA,
			5'd0, 1'b1, cache_rsp_t'{1'b1, 31'h0, 1'b0}});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h1, 31'h5555_5555,
			5'd0, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h2, 31'h1,
			5'd0, 1'b0, '0});
		// capacity lowered below the four entries held
		directed_rows.push_back('{ROW_CAPACITY, lkv_pkg::FUNC_LOOKUP, 31'h0, 31'h0,
			5'd2, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h3, 31'h3,
			5'd0, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 31'h7FFF_FFFF, 31'h0,
			5'd0, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 31'h1, 31'h0,
			5'd0, 1'b0, '0});
		// capacity zero acts as one
		directed_rows.push_back('{ROW_CAPACITY, lkv_pkg::FUNC_LOOKUP, 31'h0, 31'h0,
			5'd0, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h4, 31'h4,
			5'd0, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h5, 31'h5,
			5'd0, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 31'h3, 31'h0,
			5'd0, 1'b0, '0});
		// capacity above the slot count saturates
		directed_rows.push_back('{ROW_CAPACITY, lkv_pkg::FUNC_LOOKUP, 31'h0, 31'h0,
			5'd31, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h6, 31'h7FFF_FFFF,
			5'd0, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h7, 31'h7,
			5'd0, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 31'h0, 31'h0,
			5'd0, 1'b0, '0});
		directed_rows.push_back('{ROW_CAPACITY, lkv_pkg::FUNC_LOOKUP, 31'h0, 31'h0,
			5'd1, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_WRITE, 31'h8, 31'h8,
			5'd0, 1'b0, '0});
		directed_rows.push_back('{ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 31'h2, 31'h0,
			5'd0, 1'b0, '0});

		// single reset at the start
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.kind == ROW_CAPACITY) begin
				settle_idle();
				write_capacity(row.cap);
			end else begin
				issue_request(row.func, row.key, row.value, row.typed, row.rsp);
			end
		end

		// random phases; the lowered capacity of the second phase leaves extra entries held
		cap_plan = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd8};
		cap_plan[PHASES-1] = lkv_pkg::CAP_W'($urandom_range(31));
		for (int p = 0; p < PHASES; p++) begin
			settle_idle();
			write_capacity(cap_plan[p]);
			// one phase runs with both sides always willing
			quiet = (p == 2);
			// small key pool, edge keys mixed in, so hits and evictions are common
			key_pool.delete();
			pool_size = $urandom_range(24, 2);
			for (int j = 0; j < pool_size; j++) begin
				case ($urandom_range(9))
					0: key_pool.push_back('0);
					1: key_pool.push_back('1);
					default: key_pool.push_back(lkv_pkg::KEY_W'($urandom));
				endcase
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_size - 1)]
					: lkv_pkg::KEY_W'($urandom);
				f = ($urandom_range(99) < 55) ? lkv_pkg::FUNC_WRITE : lkv_pkg::FUNC_LOOKUP;
				issue_request(f, key, lkv_pkg::VAL_W'($urandom), 1'b0, '0);
			end
		end
		quiet = 1'b0;

		// drain, then a few sweeps more for any stray response transaction
		settle_idle();
		if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
